[design/assert_macros.svh]
// assertion macros used by the allocator datapath
// expects clk_i and rst_ni in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BBA_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define BBA_ASSERT(lbl, prop, msg)
`define BBA_NEVER(lbl, expr, msg)
`endif
`endif

[design/bba_pkg.sv]
// types and constants of the buddy block allocator
// used by every module of the block but bba_ram, depends on nothing
package bba_pkg;

  localparam int Levels = 11;
  localparam int AddrW  = 10;
  localparam int SizeW  = 11;
  localparam int StatW  = 2;
  localparam int WordW  = 32;

  localparam logic [StatW-1:0] StOk      = 2'd0;
  localparam logic [StatW-1:0] StNoSpace = 2'd1;
  localparam logic [StatW-1:0] StBad     = 2'd2;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_ALVL, S_ARD, S_ACHK, S_SRD, S_SWR,
    S_FRD, S_FCHK, S_SETRD, S_SETWR, S_FIN
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_CLR, CMD_LOAD, CMD_LVL, CMD_ARD, CMD_ACHK, CMD_SRD, CMD_SWR,
    CMD_FRD, CMD_FCHK, CMD_SETRD, CMD_SETWR, CMD_NOSP, CMD_OUT
  } cmd_e;

  typedef struct packed {
    logic clr_last;
    logic op_free;
    logic bad;
    logic lvl_over;
    logic lvl_top;
    logic lvl_at_p;
    logic hit;
    logic wa_at_end;
    logic rbit;
    logic out_busy;
  } sts_t;

endpackage

[design/bba_ram.sv]
// generic single write port, single read port ram with registered read
// no package dependency
module bba_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/bba_ctrl.sv]
// controller state machine of the buddy allocator
// depends on bba_pkg, drives commands to bba_dp
module bba_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bba_pkg::sts_t sts_i,
  output bba_pkg::cmd_e cmd_o
);

  bba_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bba_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = bba_pkg::CMD_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      bba_pkg::S_CLEAR: begin
        cmd_o = bba_pkg::CMD_CLR;
        if (sts_i.clr_last) state_d = bba_pkg::S_IDLE;
      end
      bba_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = bba_pkg::CMD_LOAD;
          state_d = bba_pkg::S_DISPATCH;
        end
      end
      bba_pkg::S_DISPATCH: begin
        if (!sts_i.op_free) state_d = bba_pkg::S_ALVL;
        else if (sts_i.bad) state_d = bba_pkg::S_FIN;
        else                state_d = bba_pkg::S_FRD;
      end
      bba_pkg::S_ALVL: begin
        if (sts_i.lvl_over) begin
          cmd_o   = bba_pkg::CMD_NOSP;
          state_d = bba_pkg::S_FIN;
        end else begin
          cmd_o   = bba_pkg::CMD_LVL;
          state_d = bba_pkg::S_ARD;
        end
      end
      bba_pkg::S_ARD: begin
        cmd_o   = bba_pkg::CMD_ARD;
        state_d = bba_pkg::S_ACHK;
      end
      bba_pkg::S_ACHK: begin
        cmd_o = bba_pkg::CMD_ACHK;
        if (sts_i.hit)            state_d = bba_pkg::S_SRD;
        else if (sts_i.wa_at_end) state_d = bba_pkg::S_ALVL;
        else                      state_d = bba_pkg::S_ARD;
      end
      bba_pkg::S_SRD: begin
        if (sts_i.lvl_at_p) begin
          state_d = bba_pkg::S_FIN;
        end else begin
          cmd_o   = bba_pkg::CMD_SRD;
          state_d = bba_pkg::S_SWR;
        end
      end
      bba_pkg::S_SWR: begin
        cmd_o   = bba_pkg::CMD_SWR;
        state_d = bba_pkg::S_SRD;
      end
      bba_pkg::S_FRD: begin
        if (sts_i.lvl_top) begin
          state_d = bba_pkg::S_SETRD;
        end else begin
          cmd_o   = bba_pkg::CMD_FRD;
          state_d = bba_pkg::S_FCHK;
        end
      end
      bba_pkg::S_FCHK: begin
        cmd_o   = bba_pkg::CMD_FCHK;
        state_d = sts_i.rbit ? bba_pkg::S_FRD : bba_pkg::S_SETRD;
      end
      bba_pkg::S_SETRD: begin
        cmd_o   = bba_pkg::CMD_SETRD;
        state_d = bba_pkg::S_SETWR;
      end
      bba_pkg::S_SETWR: begin
        cmd_o   = bba_pkg::CMD_SETWR;
        state_d = bba_pkg::S_FIN;
      end
      bba_pkg::S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o   = bba_pkg::CMD_OUT;
          state_d = bba_pkg::S_IDLE;
        end
      end
      default: state_d = bba_pkg::S_IDLE;
    endcase
  end

endmodule

[design/bba_dp.sv]
// datapath of the buddy allocator: free-flag ram, walk registers, result register
// depends on bba_pkg, bba_ram and assert_macros.svh
`include "assert_macros.svh"
module bba_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bba_pkg::cmd_e             cmd_i,
  input  logic                      opcode_i,
  input  logic [bba_pkg::SizeW-1:0] size_i,
  input  logic [bba_pkg::AddrW-1:0] start_i,
  output bba_pkg::sts_t             sts_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [bba_pkg::StatW-1:0] out_status_o,
  output logic [bba_pkg::AddrW-1:0] out_start_o,
  output logic [bba_pkg::AddrW-1:0] out_last_o
);

  localparam int LEVELS = bba_pkg::Levels;
  localparam int T  = LEVELS - 1;
  localparam int LW = $clog2(LEVELS + 1);
  localparam int IW = (LEVELS < 6) ? 6 : LEVELS;
  localparam int AW = IW - 5;
  localparam int NW = 1 << AW;
  localparam int AddrW = bba_pkg::AddrW;

  function automatic logic [31:0] base_idx(input logic [LW-1:0] lvl);
    base_idx = (32'd1 << (T - int'(lvl))) - 32'd1;
  endfunction

  function automatic logic [IW-1:0] node_idx(input logic [LW-1:0] lvl,
                                             input logic [AddrW-1:0] a);
    node_idx = IW'(base_idx(lvl) + (32'(a) >> lvl));
  endfunction

  logic                      op_q;
  logic [LW-1:0]             p_q, lvl_q, p_calc;
  logic [AddrW-1:0]          s_q;
  logic [AW-1:0]             wa_q;
  logic [IW-1:0]             idx_q;
  logic [bba_pkg::StatW-1:0] st_q;
  logic                      out_vld_q;
  logic [bba_pkg::StatW-1:0] out_st_q;
  logic [AddrW-1:0]          out_start_q, out_last_q;

  logic                      re, we;
  logic [AW-1:0]             raddr, waddr;
  logic [bba_pkg::WordW-1:0] wdata, rdata, amask;
  logic [31:0]               lvl_base, lvl_last, found;
  logic [AW-1:0]             wa_first, wa_end;
  logic                      hit, rbit, bad_calc;
  logic [4:0]                hit_b;
  logic [LW-1:0]             nl;
  logic [IW-1:0]             sidx, bidx, setidx;
  logic [AddrW-1:0]          s_new;

  bba_ram #(.Width(bba_pkg::WordW), .Depth(NW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // requested level: count of powers of two below the size
  always_comb begin
    p_calc = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if ((32'd1 << i) < 32'(size_i)) p_calc = p_calc + LW'(1);
    end
    bad_calc = (int'(p_calc) > T) || (32'(start_i) >= (32'd1 << T)) ||
               ((32'(start_i) & ((32'd1 << p_calc) - 32'd1)) != 32'd0);
  end

  always_comb begin
    lvl_base = base_idx(lvl_q);
    lvl_last = (lvl_base << 1);
    wa_first = AW'(lvl_base >> 5);
    wa_end   = AW'(lvl_last >> 5);
    for (int b = 0; b < bba_pkg::WordW; b++) begin
      amask[b] = rdata[b] && (32'({wa_q, 5'(b)}) >= lvl_base) &&
                 (32'({wa_q, 5'(b)}) <= lvl_last);
    end
    hit   = |amask;
    hit_b = '0;
    for (int b = bba_pkg::WordW - 1; b >= 0; b--) begin
      if (amask[b]) hit_b = 5'(b);
    end
    found  = 32'({wa_q, hit_b}) - lvl_base;
    s_new  = AddrW'(found << lvl_q);
    nl     = lvl_q - LW'(1);
    sidx   = node_idx(nl, s_q | AddrW'(32'd1 << nl));
    bidx   = node_idx(lvl_q, s_q ^ AddrW'(32'd1 << lvl_q));
    setidx = node_idx(lvl_q, s_q);
    rbit   = rdata[idx_q[4:0]];
  end

  always_comb begin
    re    = 1'b0;
    we    = 1'b0;
    raddr = wa_q;
    waddr = idx_q[IW-1:5];
    wdata = rdata;
    unique case (cmd_i)
      bba_pkg::CMD_CLR: begin
        we    = 1'b1;
        waddr = wa_q;
        // only the top node, index zero, starts free
        wdata = (wa_q == '0) ? bba_pkg::WordW'(1) : '0;
      end
      bba_pkg::CMD_ARD: re = 1'b1;
      bba_pkg::CMD_ACHK: begin
        we    = hit;
        waddr = wa_q;
        wdata = rdata & ~(bba_pkg::WordW'(1) << hit_b);
      end
      bba_pkg::CMD_SRD: begin
        re    = 1'b1;
        raddr = sidx[IW-1:5];
      end
      bba_pkg::CMD_SWR: begin
        we    = 1'b1;
        wdata = rdata | (bba_pkg::WordW'(1) << idx_q[4:0]);
      end
      bba_pkg::CMD_FRD: begin
        re    = 1'b1;
        raddr = bidx[IW-1:5];
      end
      bba_pkg::CMD_FCHK: begin
        we    = rbit;
        wdata = rdata & ~(bba_pkg::WordW'(1) << idx_q[4:0]);
      end
      bba_pkg::CMD_SETRD: begin
        re    = 1'b1;
        raddr = setidx[IW-1:5];
      end
      bba_pkg::CMD_SETWR: begin
        we    = 1'b1;
        wdata = rdata | (bba_pkg::WordW'(1) << idx_q[4:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wa_q      <= '0;
      out_vld_q <= 1'b0;
      op_q      <= 1'b0;
      p_q       <= '0;
      lvl_q     <= '0;
      st_q      <= bba_pkg::StOk;
    end else begin
      if (cmd_i == bba_pkg::CMD_OUT) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (cmd_i)
        bba_pkg::CMD_CLR: wa_q <= wa_q + AW'(1);
        bba_pkg::CMD_LOAD: begin
          op_q  <= opcode_i;
          p_q   <= p_calc;
          lvl_q <= p_calc;
          st_q  <= (opcode_i == bba_pkg::OpFree && bad_calc) ? bba_pkg::StBad
                                                             : bba_pkg::StOk;
        end
        bba_pkg::CMD_LVL: wa_q <= wa_first;
        bba_pkg::CMD_ACHK: begin
          if (hit)                 ;
          else if (wa_q == wa_end) lvl_q <= lvl_q + LW'(1);
          else                     wa_q  <= wa_q + AW'(1);
        end
        bba_pkg::CMD_SWR: lvl_q <= nl;
        bba_pkg::CMD_FCHK: if (rbit) lvl_q <= lvl_q + LW'(1);
        bba_pkg::CMD_NOSP: st_q <= bba_pkg::StNoSpace;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      bba_pkg::CMD_LOAD: s_q <= start_i;
      bba_pkg::CMD_ACHK: if (hit) s_q <= s_new;
      bba_pkg::CMD_SRD:  idx_q <= sidx;
      bba_pkg::CMD_FRD:  idx_q <= bidx;
      bba_pkg::CMD_SETRD: idx_q <= setidx;
      bba_pkg::CMD_FCHK: if (rbit) s_q <= s_q & ~AddrW'(32'd1 << lvl_q);
      bba_pkg::CMD_OUT: begin
        out_st_q <= st_q;
        if (op_q == bba_pkg::OpAlloc && st_q == bba_pkg::StOk) begin
          out_start_q <= s_q;
          out_last_q  <= s_q + AddrW'((32'd1 << p_q) - 32'd1);
        end else begin
          out_start_q <= '0;
          out_last_q  <= '0;
        end
      end
      default: ;
    endcase
  end

  assign sts_o.clr_last  = (wa_q == AW'(NW - 1));
  assign sts_o.op_free   = (op_q == bba_pkg::OpFree);
  assign sts_o.bad       = (st_q == bba_pkg::StBad);
  assign sts_o.lvl_over  = (int'(lvl_q) > T);
  assign sts_o.lvl_top   = (int'(lvl_q) == T);
  assign sts_o.lvl_at_p  = (lvl_q == p_q);
  assign sts_o.hit       = hit;
  assign sts_o.wa_at_end = (wa_q == wa_end);
  assign sts_o.rbit      = rbit;
  assign sts_o.out_busy  = out_vld_q && !out_ready_i;

  assign out_valid_o  = out_vld_q;
  assign out_status_o = out_st_q;
  assign out_start_o  = out_start_q;
  assign out_last_o   = out_last_q;

  `BBA_NEVER(a_no_rw_same, re && we, "ram read and write in one cycle")
  `BBA_ASSERT(a_out_free, (cmd_i == bba_pkg::CMD_OUT) |-> !(out_vld_q && !out_ready_i), "result overwrites a pending item")
  `BBA_ASSERT(a_split_above, (cmd_i == bba_pkg::CMD_SWR) |-> (lvl_q > p_q), "split below requested level")

endmodule

[design/buddy_block_allocator_top.sv]
// buddy allocator: one item at a time. an allocate scans the ram words of each level, from
// the requested level upward, clears the first free node found and splits it down to size;
// a free is answered at once when rejected, else merges with its buddy while that is free.
// tready rises in the same cycle the result goes valid; a waiting result holds the walk.
// after reset, clearing all 64 ram words holds tready low; reset is asynchronous, active low.
module buddy_block_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // size_bytes[10:0], start_address[20:11], last_address[30:21]
  input  logic        s_axis_tuser_i,  // opcode[0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // block_start[9:0], block_last[19:10]
  output logic [1:0]  m_axis_tuser_o   // status[1:0]
);

  bba_pkg::cmd_e cmd;
  bba_pkg::sts_t sts;
  logic [bba_pkg::AddrW-1:0] blk_start, blk_last;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bba_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .opcode_i     (s_axis_tuser_i),
    .size_i       (s_axis_tdata_i[10:0]),
    .start_i      (s_axis_tdata_i[20:11]),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (m_axis_tuser_o),
    .out_start_o  (blk_start),
    .out_last_o   (blk_last)
  );

  // last address is carried on the bus but the block end follows from its size
  assign m_axis_tdata_o = {4'b0, blk_last, blk_start};

endmodule
